// ----- rtl/moved_disc_exposed_spans_macros.svh -----
// Assertion macros shared by the span block.
`ifndef MOVED_DISC_EXPOSED_SPANS_MACROS_SVH
`define MOVED_DISC_EXPOSED_SPANS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MDES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MDES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mdes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdes_pkg
// Types, constants and the square root step used by the moved disc span block.
// ----------------------------------------------------------------------------
package mdes_pkg;

    localparam int DATA_W     = 64;
    localparam int SQRT_STEPS = 6;
    // Highest power of four that the 12 bit radicand may hold, as a shift.
    localparam int SQRT_TOP   = 2 * (SQRT_STEPS - 1);

    typedef struct packed {
        logic signed [10:0] ocx;
        logic signed [10:0] ncx;
        logic signed [11:0] y;
        logic signed [12:0] ndy;
        logic        [5:0]  orad;
        logic        [5:0]  nrad;
        logic signed [6:0]  dy;
    } t_s0;

    typedef struct packed {
        logic signed [10:0] ocx;
        logic signed [10:0] ncx;
        logic signed [11:0] y;
        logic               outside;
    } t_ctx;

    typedef struct packed {
        logic [11:0] osq;
        logic [12:0] odsq;
        logic [11:0] nsq;
        logic [12:0] ndsq;
    } t_sq;

    typedef struct packed {
        logic [11:0] rem;
        logic [11:0] root;
    } t_root;

    typedef struct packed {
        logic [1:0]         pad;
        logic signed [11:0] second_end;
        logic signed [11:0] second_start;
        logic               second_valid;
        logic signed [11:0] first_end;
        logic signed [11:0] first_start;
        logic               first_valid;
        logic signed [11:0] row_y;
    } t_out;

    // One digit of the restoring square root; step 0 tests the top power of four.
    function automatic t_root root_step(input t_root s, input int k);
        t_root       r;
        logic [12:0] bit_v;
        logic [12:0] trial;
        bit_v = 13'(1) << (SQRT_TOP - 2 * k);
        trial = {1'b0, s.root} + bit_v;
        r = s;
        if ({1'b0, s.rem} >= trial) begin
            r.rem  = 12'({1'b0, s.rem} - trial);
            r.root = 12'(({1'b0, s.root} >> 1) + bit_v);
        end else begin
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/moved_disc_exposed_spans.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moved_disc_exposed_spans
// Spans of one scan row that an old disc covered and a moved disc does not.
// ----------------------------------------------------------------------------
// The feeder sends one word per scan row of the old disc on the s_axis side:
// old and new centre, both radii and the row offset from the old centre. For
// each word one result word leaves on the m_axis side: the absolute row and up
// to two spans to erase. A row outside the new disc yields one span covering
// the whole old row; otherwise a left and a right edge span may be present.
// Absent spans carry zero start and end.
//
// One word is accepted per clock while s_axis_tready is high. The work runs
// through seven registers: input stage, squaring, radicand, three stages of
// two square root digits each, and the output register where spans are
// compared and formed.
//
// Reset (i_rst_n low at a clock edge) empties every stage. When the receiver
// stalls, words advance into empty stages behind the output register, so
// s_axis_tready falls only once all seven stages hold a word.
// ----------------------------------------------------------------------------
`include "moved_disc_exposed_spans_macros.svh"

module moved_disc_exposed_spans
    import mdes_pkg::*;
#(
    parameter int MAX_RADIUS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // old_center_x[10:0], old_center_y[21:11], old_rad[27:22], new_center_x[38:28],
    // new_center_y[49:39], new_rad[55:50], row_offset[62:56], zero[63]
    input  logic [DATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // row_y[11:0], first_valid[12], first_start[24:13], first_end[36:25],
    // second_valid[37], second_start[49:38], second_end[61:50], zero[63:62]
    output logic [DATA_W-1:0] m_axis_tdata
);

    localparam logic [7:0] RAD_LIMIT = 8'(MAX_RADIUS);

    function automatic logic [5:0] sat_rad(input logic [5:0] r);
        if ({2'b00, r} > RAD_LIMIT) begin
            return RAD_LIMIT[5:0];
        end
        return r;
    endfunction

    logic [5:0] r_v;
    logic       r_ov;
    logic [6:0] w_rdy;

    t_s0   r_s0, n_s0;
    t_ctx  r_ctx [1:5];
    t_ctx  n_ctx1;
    t_sq   r_sq, n_sq;
    t_root r_ro  [2:5];
    t_root r_rn  [2:5];
    t_root n_ro2, n_rn2;
    t_out  r_out, n_out;

    logic signed [10:0] w_ocy;
    logic signed [10:0] w_ncy;
    logic signed [6:0]  w_roff;
    logic signed [11:0] w_y;
    logic signed [12:0] w_nr13;
    logic signed [6:0]  w_nd7;
    logic signed [13:0] w_odsq;
    logic signed [13:0] w_ndsq;
    logic signed [12:0] w_oleft, w_oright, w_nleft, w_nright;

    // A stage can load when it is empty or its word moves on this cycle.
    always_comb begin
        w_rdy[6] = !r_ov || m_axis_tready;
        for (int k = 5; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    // Input stage: unpack, saturate radii, absolute row and row distance to new centre.
    always_comb begin
        w_ocy       = s_axis_tdata[21:11];
        w_ncy       = s_axis_tdata[49:39];
        w_roff      = s_axis_tdata[62:56];
        w_y         = 12'(w_ocy) + 12'(w_roff);
        n_s0.ocx    = s_axis_tdata[10:0];
        n_s0.ncx    = s_axis_tdata[38:28];
        n_s0.orad   = sat_rad(s_axis_tdata[27:22]);
        n_s0.nrad   = sat_rad(s_axis_tdata[55:50]);
        n_s0.dy     = w_roff;
        n_s0.y      = w_y;
        n_s0.ndy    = 13'(w_y) - 13'(w_ncy);
    end

    // Squaring stage. Inside the new disc the row distance fits seven signed bits.
    always_comb begin
        w_nr13         = $signed({7'b0, r_s0.nrad});
        n_ctx1.ocx     = r_s0.ocx;
        n_ctx1.ncx     = r_s0.ncx;
        n_ctx1.y       = r_s0.y;
        n_ctx1.outside = (r_s0.ndy > w_nr13) || (r_s0.ndy < -w_nr13);
        w_nd7          = n_ctx1.outside ? 7'sd0 : r_s0.ndy[6:0];
        w_odsq         = 14'(r_s0.dy) * 14'(r_s0.dy);
        w_ndsq         = 14'(w_nd7) * 14'(w_nd7);
        n_sq.osq       = {6'b0, r_s0.orad} * {6'b0, r_s0.orad};
        n_sq.nsq       = {6'b0, r_s0.nrad} * {6'b0, r_s0.nrad};
        n_sq.odsq      = w_odsq[12:0];
        n_sq.ndsq      = w_ndsq[12:0];
    end

    // Radicand stage: r*r - d*d, clamped at zero.
    always_comb begin
        n_ro2.root = '0;
        n_rn2.root = '0;
        n_ro2.rem  = ({1'b0, r_sq.osq} > r_sq.odsq) ?
                     12'({1'b0, r_sq.osq} - r_sq.odsq) : 12'd0;
        n_rn2.rem  = ({1'b0, r_sq.nsq} > r_sq.ndsq) ?
                     12'({1'b0, r_sq.nsq} - r_sq.ndsq) : 12'd0;
    end

    // Output stage: edges of both discs and the spans between them.
    always_comb begin
        w_oleft  = 13'(r_ctx[5].ocx) - 13'({1'b0, r_ro[5].root[5:0]});
        w_oright = 13'(r_ctx[5].ocx) + 13'({1'b0, r_ro[5].root[5:0]});
        w_nleft  = 13'(r_ctx[5].ncx) - 13'({1'b0, r_rn[5].root[5:0]});
        w_nright = 13'(r_ctx[5].ncx) + 13'({1'b0, r_rn[5].root[5:0]});
        n_out    = '0;
        n_out.row_y = r_ctx[5].y;
        if (r_ctx[5].outside) begin
            n_out.first_valid = 1'b1;
            n_out.first_start = w_oleft[11:0];
            n_out.first_end   = w_oright[11:0];
        end else begin
            if (w_oleft < w_nleft) begin
                n_out.first_valid = 1'b1;
                n_out.first_start = w_oleft[11:0];
                n_out.first_end   = 12'(w_nleft - 13'sd1);
            end
            if (w_oright > w_nright) begin
                n_out.second_valid = 1'b1;
                n_out.second_start = 12'(w_nright + 13'sd1);
                n_out.second_end   = w_oright[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= 5; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_rdy[6]) begin
                r_ov <= r_v[5];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && s_axis_tvalid) begin
            r_s0 <= n_s0;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_ctx[1] <= n_ctx1;
            r_sq     <= n_sq;
        end
        if (w_rdy[2] && r_v[1]) begin
            r_ctx[2] <= r_ctx[1];
            r_ro[2]  <= n_ro2;
            r_rn[2]  <= n_rn2;
        end
        // Two square root digits per stage for both discs.
        for (int k = 3; k <= 5; k++) begin
            if (w_rdy[k] && r_v[k-1]) begin
                r_ctx[k] <= r_ctx[k-1];
                r_ro[k]  <= root_step(root_step(r_ro[k-1], 2 * (k - 3)), 2 * (k - 3) + 1);
                r_rn[k]  <= root_step(root_step(r_rn[k-1], 2 * (k - 3)), 2 * (k - 3) + 1);
            end
        end
        if (w_rdy[6] && r_v[5]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    `MDES_ASSERT_IMP(a_no_bubble_stall, !s_axis_tready,
                     (&r_v) && r_ov && !m_axis_tready, "input stalled with an empty stage")
    `MDES_ASSERT_IMP(a_first_order, r_ov && r_out.first_valid,
                     r_out.first_start <= r_out.first_end, "first span reversed")
    `MDES_ASSERT_IMP(a_second_order, r_ov && r_out.second_valid,
                     r_out.second_start <= r_out.second_end, "second span reversed")
    `MDES_ASSERT_NXT(a_out_load, w_rdy[6] && r_v[5], r_ov, "word lost at output register")

endmodule
